// File: src/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 encrypt package
// Shared types, S-box, round constants and round helper functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int NumRounds = 10;

	typedef logic [127:0] blk_t;
	typedef logic [7:0]   byte_t;

	typedef struct packed {
		logic valid;
		blk_t state;
		blk_t rkey;
	} stage_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	localparam byte_t GfPoly = 8'h1b;

	// Byte i of a block, byte 0 in the top bits.
	function automatic byte_t get_byte(input blk_t b, input int i);
		get_byte = b[127-8*i -: 8];
	endfunction

	function automatic byte_t gf_double(input byte_t x);
		gf_double = {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
	endfunction

	// Advance the round key by one round.
	function automatic blk_t next_key(input blk_t k, input byte_t rc);
		logic [31:0] w [4];
		logic [31:0] t;
		blk_t r;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
			SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		r = {w[0], w[1], w[2], w[3]};
		return r;
	endfunction

	// SubBytes and ShiftRows together.
	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
		return t;
	endfunction

	function automatic blk_t mix_cols(input blk_t s);
		blk_t t;
		byte_t a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
			t[127-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
			t[127-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
			t[127-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

// File: src/block_cipher_encrypt_128.sv
// ----------------------------------------------------------------------------
// AES-128 encrypt, fully pipelined
// Eleven-stage pipeline: initial key add, then one stage per round.
// ----------------------------------------------------------------------------
// A word is taken at every clock where start is high; busy is always low.
// Each word's ciphertext passes the key-add register and then one register
// stage per round, and leaves with done high for one cycle; a new word may
// enter every cycle. The receiver cannot stall the pipeline.
module block_cipher_encrypt_128 import aes128_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	output logic        done,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	stage_t pipe [NumRounds+1];
	logic valid_s0;
	blk_t state_s0;
	blk_t rkey_s0;

	assign busy = 1'b0;

	// Initial key addition
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start;
		end
	end

	always_ff @(posedge clk) begin
		state_s0 <= {plain_high, plain_low} ^ {key_high, key_low};
		rkey_s0 <= {key_high, key_low};
	end

	assign pipe[0] = '{valid: valid_s0, state: state_s0, rkey: rkey_s0};

	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		aes128_round #(.Round(r)) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.din(pipe[r]),
			.dout(pipe[r+1])
		);
	end

	assign done = pipe[NumRounds].valid;
	assign cipher_high = pipe[NumRounds].state[127:64];
	assign cipher_low = pipe[NumRounds].state[63:0];

	// Every accepted word emerges after the full pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(NumRounds+1) done) else $error("result lost in pipeline");

	// No result without a word entering earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NumRounds+1)) else $error("spurious result");

endmodule

// File: src/aes128_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered cipher round with its key schedule step.
// ----------------------------------------------------------------------------
module aes128_round import aes128_pkg::*; #(
	parameter int Round = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t din,
	output stage_t dout
);

	localparam bit LastRound = (Round == NumRounds - 1);

	blk_t key_nxt;
	blk_t sh;
	blk_t mixed;
	logic valid_s;
	blk_t state_s;
	blk_t rkey_s;

	// Compute the round and the next round key
	always_comb begin
		key_nxt = next_key(din.rkey, RCON[Round]);
		sh = sub_shift(din.state);
		mixed = LastRound ? sh : mix_cols(sh);
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= din.valid;
		end
	end

	// Register the word
	always_ff @(posedge clk) begin
		state_s <= mixed ^ key_nxt;
		rkey_s <= key_nxt;
	end

	assign dout = '{valid: valid_s, state: state_s, rkey: rkey_s};

endmodule
